// File: hdl/font_glyph_address_lookup_top_macros.svh
// assertion helpers for the glyph address lookup block
`ifndef FONT_GLYPH_ADDRESS_LOOKUP_TOP_MACROS_SVH
`define FONT_GLYPH_ADDRESS_LOOKUP_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define FGAL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define FGAL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/fgal_pkg.sv
package fgal_pkg;

    localparam int DEF_MAX_BLOCKS = 256;
    // power of two, pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;

    localparam int CODE_W   = 16;
    localparam int LEN_W    = 16;
    localparam int BIDX_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 3;
    localparam int REGIDX_W = 2;
    localparam int PROD_W   = CODE_W + SIZE_W;

    localparam logic [CODE_W-1:0] CODE_LIMIT = 16'h0100;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SMALL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd3;

    // request kinds
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // code types
    localparam logic CODE_SINGLE = 1'b0;

    // classified operation kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SMALL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ABSENT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIRECT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WALK   = 3'd4;

    // register indexes
    localparam logic [REGIDX_W-1:0] REG_CODE_TYPE    = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_PATTERN_BASE = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_PATTERN_SIZE = 2'd2;
    localparam logic [REGIDX_W-1:0] REG_BLOCK_COUNT  = 2'd3;

    typedef struct packed {
        logic               code_type;
        logic [ADDR_W-1:0]  pattern_base;
        logic [SIZE_W-1:0]  pattern_size;
        logic [COUNT_W-1:0] block_count;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              load_ok;
        logic [BIDX_W-1:0] block_index;
        logic [CODE_W-1:0] char_code;
        logic [CODE_W-1:0] block_first;
        logic [CODE_W-1:0] block_last;
    } op_t;

endpackage

// File: hdl/fgal_front.sv
module fgal_front #(
    parameter int MAX_BLOCKS = fgal_pkg::DEF_MAX_BLOCKS
) (
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // char_code, buffer_len, block_index, block_first, block_last
    input  logic [71:0]   s_axis_tdata,
    // req_type
    input  logic          s_axis_tuser,
    input  fgal_pkg::cfg_t cfg_i,
    input  logic          q_full,
    output logic          q_push,
    output fgal_pkg::op_t push_op
);

    logic [fgal_pkg::CODE_W-1:0] char_code;
    logic [fgal_pkg::LEN_W-1:0]  buffer_len;
    logic [fgal_pkg::BIDX_W-1:0] block_index;

    assign char_code   = s_axis_tdata[15:0];
    assign buffer_len  = s_axis_tdata[31:16];
    assign block_index = s_axis_tdata[39:32];

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb begin
        push_op             = '0;
        push_op.char_code   = char_code;
        push_op.block_index = block_index;
        push_op.block_first = s_axis_tdata[55:40];
        push_op.block_last  = s_axis_tdata[71:56];
        // loads past the table end still answer, but write nothing
        push_op.load_ok     = ({1'b0, block_index} < 9'(MAX_BLOCKS));
        if (s_axis_tuser == fgal_pkg::REQ_LOAD) begin
            push_op.kind = fgal_pkg::KIND_LOAD;
        end else if ({8'b0, cfg_i.pattern_size} > buffer_len) begin
            push_op.kind = fgal_pkg::KIND_SMALL;
        end else if (cfg_i.code_type == fgal_pkg::CODE_SINGLE) begin
            if (char_code >= fgal_pkg::CODE_LIMIT) begin
                push_op.kind = fgal_pkg::KIND_ABSENT;
            end else begin
                push_op.kind = fgal_pkg::KIND_DIRECT;
            end
        end else if (cfg_i.block_count == '0) begin
            push_op.kind = fgal_pkg::KIND_ABSENT;
        end else begin
            push_op.kind = fgal_pkg::KIND_WALK;
        end
    end

endmodule

// File: hdl/fgal_queue.sv
module fgal_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_push,
    input  fgal_pkg::op_t push_op,
    input  logic          q_pop,
    output fgal_pkg::op_t head_op,
    output logic          q_empty,
    output logic          q_full
);

    localparam int PTR_W = (fgal_pkg::QUEUE_DEPTH > 1) ? $clog2(fgal_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(fgal_pkg::QUEUE_DEPTH + 1);

    fgal_pkg::op_t    ent_reg [fgal_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == CNT_W'(fgal_pkg::QUEUE_DEPTH));
    assign head_op = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (q_push) begin
            wr_ptr_next = PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (q_pop) begin
            rd_ptr_next = PTR_W'(rd_ptr_reg + 1'b1);
        end
        case ({q_push, q_pop})
            2'b10:   cnt_next = CNT_W'(cnt_reg + 1'b1);
            2'b01:   cnt_next = CNT_W'(cnt_reg - 1'b1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            ent_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: hdl/fgal_back.sv
module fgal_back #(
    parameter int MAX_BLOCKS = fgal_pkg::DEF_MAX_BLOCKS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  fgal_pkg::cfg_t cfg_i,
    input  logic           q_empty,
    input  fgal_pkg::op_t  head_op,
    output logic           q_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // glyph_address
    output logic [31:0]    m_axis_tdata,
    // status
    output logic [1:0]     m_axis_tuser
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    logic [fgal_pkg::CODE_W-1:0]   code_reg, code_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next, cnt_inc;
    logic [fgal_pkg::CODE_W-1:0]   idx_reg, idx_next;
    logic [fgal_pkg::CODE_W-1:0]   lin_reg, lin_next;
    logic [fgal_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [fgal_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [fgal_pkg::ADDR_W-1:0]   res_addr_reg, res_addr_next;

    logic [31:0]      blk_mem [MAX_BLOCKS];
    logic [31:0]      rd_data_reg;
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr;

    logic [CNT_W-1:0]            n_blocks;
    logic [fgal_pkg::CODE_W-1:0] blk_first, blk_last;
    logic                        hit;

    logic                        m_valid_reg;
    logic [fgal_pkg::STATUS_W-1:0] m_status_reg;
    logic [fgal_pkg::ADDR_W-1:0] m_addr_reg;
    logic                        out_free;

    // counts above the table size walk the whole table
    assign n_blocks = (cfg_i.block_count > 9'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                            : cfg_i.block_count[CNT_W-1:0];
    assign blk_first = rd_data_reg[15:0];
    assign blk_last  = rd_data_reg[31:16];
    assign hit       = (code_reg >= blk_first) && (code_reg <= blk_last);
    assign cnt_inc   = CNT_W'(cnt_reg + 1'b1);
    assign out_free  = !m_valid_reg || m_axis_tready;

    always_comb begin
        state_next      = state_reg;
        code_next       = code_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        lin_next        = lin_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        q_pop           = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop         = 1'b1;
                    code_next     = head_op.char_code;
                    res_addr_next = '0;
                    case (head_op.kind)
                        fgal_pkg::KIND_LOAD: begin
                            wr_en           = head_op.load_ok;
                            res_status_next = fgal_pkg::ST_LOADED;
                            state_next      = S_EMIT;
                        end
                        fgal_pkg::KIND_SMALL: begin
                            res_status_next = fgal_pkg::ST_SMALL;
                            state_next      = S_EMIT;
                        end
                        fgal_pkg::KIND_DIRECT: begin
                            lin_next   = head_op.char_code;
                            state_next = S_MUL;
                        end
                        fgal_pkg::KIND_WALK: begin
                            rd_en      = 1'b1;
                            cnt_next   = '0;
                            idx_next   = '0;
                            state_next = S_WALK;
                        end
                        default: begin
                            res_status_next = fgal_pkg::ST_ABSENT;
                            state_next      = S_EMIT;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // rd_data_reg holds the block at cnt_reg, next one is fetched ahead
                if (hit) begin
                    lin_next   = idx_reg + code_reg - blk_first;
                    state_next = S_MUL;
                end else begin
                    idx_next = idx_reg + (blk_last - blk_first) + 16'd1;
                    cnt_next = cnt_inc;
                    if (cnt_inc == n_blocks) begin
                        res_status_next = fgal_pkg::ST_ABSENT;
                        res_addr_next   = '0;
                        state_next      = S_EMIT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = cnt_inc[IDX_W-1:0];
                    end
                end
            end
            S_MUL: begin
                prod_next  = fgal_pkg::PROD_W'(lin_reg) * fgal_pkg::PROD_W'(cfg_i.pattern_size);
                state_next = S_ADD;
            end
            S_ADD: begin
                res_addr_next   = cfg_i.pattern_base + {8'b0, prod_reg};
                res_status_next = fgal_pkg::ST_FOUND;
                state_next      = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg       <= code_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        lin_reg        <= lin_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
    end

    // range table, first in the low half, last in the high half
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            blk_mem[head_op.block_index[IDX_W-1:0]] <=
                {head_op.block_last, head_op.block_first};
        end
        if (rd_en) begin
            rd_data_reg <= blk_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && out_free) begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= res_addr_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_addr_reg;
    assign m_axis_tuser  = m_status_reg;

endmodule

// File: hdl/font_glyph_address_lookup_top.sv
// from input beat to result beat: loads, refusals and codes absent without a walk go
// straight to emit; single-byte hits pass through multiply and add; double-byte lookups
// first walk the range table, one range block per cycle through the table ram's
// registered read port; the back end ends one item before it pops another from the queue
// reset: synchronous active-low aresetn clears control and config registers; range table
// contents are undefined until loaded, no clearing pass
`include "font_glyph_address_lookup_top_macros.svh"

module font_glyph_address_lookup_top #(
    parameter int MAX_BLOCKS = fgal_pkg::DEF_MAX_BLOCKS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[15:0], buffer_len[31:16], block_index[39:32],
    // block_first[55:40], block_last[71:56]
    input  logic [71:0] s_axis_tdata,
    // req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // glyph_address
    output logic [31:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    fgal_pkg::cfg_t cfg_reg;
    fgal_pkg::op_t  push_op, head_op;
    logic           q_push, q_pop, q_empty, q_full;
    logic           res_not_found;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_type    <= 1'b0;
            cfg_reg.pattern_base <= '0;
            cfg_reg.pattern_size <= 8'd1;
            cfg_reg.block_count  <= 9'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                fgal_pkg::REG_CODE_TYPE:    cfg_reg.code_type    <= cfg_data[0];
                fgal_pkg::REG_PATTERN_BASE: cfg_reg.pattern_base <= cfg_data;
                fgal_pkg::REG_PATTERN_SIZE: cfg_reg.pattern_size <= cfg_data[7:0];
                fgal_pkg::REG_BLOCK_COUNT:  cfg_reg.block_count  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    fgal_front #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_front (
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .cfg_i        (cfg_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .push_op      (push_op)
    );

    fgal_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_push (q_push),
        .push_op(push_op),
        .q_pop  (q_pop),
        .head_op(head_op),
        .q_empty(q_empty),
        .q_full (q_full)
    );

    fgal_back #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_i        (cfg_reg),
        .q_empty      (q_empty),
        .head_op      (head_op),
        .q_pop        (q_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    assign res_not_found = m_axis_tvalid && (m_axis_tuser != fgal_pkg::ST_FOUND);

    `FGAL_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")
    `FGAL_ASSERT_NXT(a_push_fills, q_push && !q_pop && q_empty, !q_empty, "queue push lost")
    `FGAL_ASSERT_IMP(a_addr_zero, res_not_found, m_axis_tdata == '0, "address on non-found")

endmodule

// File: verif/tb_font_glyph_address_lookup_top.sv
module tb_font_glyph_address_lookup_top;
    import fgal_pkg::*;

    localparam int  MAX_RANGES     = DEF_MAX_BLOCKS;
    localparam logic CODE_DOUBLE   = 1'b1;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  DRAIN_CYCLES   = MAX_RANGES + 16;

    typedef struct packed {
        logic        req_type;
        logic [15:0] char_code;
        logic [15:0] buffer_len;
        logic [7:0]  block_index;
        logic [15:0] block_first;
        logic [15:0] block_last;
    } glyph_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr;
    } glyph_result_t;

    typedef struct packed {
        logic          is_reg;
        logic [1:0]    reg_idx;
        logic [31:0]   reg_val;
        glyph_req_t    req;
        logic          typed;
        glyph_result_t want;
    } script_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow copy of the block's registers and range table
    logic        shadow_code_type = 1'b0;
    logic [31:0] shadow_base      = 32'd0;
    logic [7:0]  shadow_size      = 8'd1;
    logic [8:0]  shadow_blocks    = 9'd1;
    logic [15:0] ranges_first [MAX_RANGES];
    logic [15:0] ranges_last  [MAX_RANGES];

    glyph_result_t pending_glyphs [$];
    script_row_t   script [$];

    int unsigned src_idle_pct = 10;
    int unsigned dst_idle_pct = 85;
    int unsigned mismatches   = 0;
    int unsigned beats_checked = 0;
    int unsigned reg_writes   = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};
    int unsigned holds_done   = 0;
    int unsigned hold_left    = 0;
    int unsigned quiet_cycles = 0;

    font_glyph_address_lookup_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic glyph_result_t predict_glyph(input glyph_req_t r);
        glyph_result_t res;
        int unsigned   walk_n;
        logic [15:0]   run_idx;
        logic [15:0]   hit_idx;
        logic          found;
        res.status = ST_ABSENT;
        res.addr   = 32'd0;
        found      = 1'b0;
        run_idx    = 16'd0;
        if (r.req_type == REQ_LOAD) begin
            ranges_first[r.block_index] = r.block_first;
            ranges_last[r.block_index]  = r.block_last;
            res.status = ST_LOADED;
        end else if ({8'd0, shadow_size} > r.buffer_len) begin
            res.status = ST_SMALL;
        end else if (shadow_code_type == CODE_SINGLE) begin
            if (r.char_code < CODE_LIMIT) begin
                res.status = ST_FOUND;
                res.addr   = shadow_base + {16'd0, r.char_code} * {24'd0, shadow_size};
            end
        end else begin
            walk_n = (shadow_blocks > MAX_RANGES) ? MAX_RANGES : shadow_blocks;
            for (int i = 0; i < walk_n; i++) begin
                if (!found && r.char_code >= ranges_first[i]
                        && r.char_code <= ranges_last[i]) begin
                    found      = 1'b1;
                    hit_idx    = run_idx + (r.char_code - ranges_first[i]);
                    res.status = ST_FOUND;
                    res.addr   = shadow_base + {16'd0, hit_idx} * {24'd0, shadow_size};
                end
                // inverted ranges still advance the index, wrapping at 16 bits
                run_idx = run_idx + (ranges_last[i] - ranges_first[i]) + 16'd1;
            end
        end
        return res;
    endfunction

    function automatic glyph_req_t lookup_req(input logic [15:0] code, input logic [15:0] blen);
        glyph_req_t r;
        r            = '0;
        r.req_type   = REQ_LOOKUP;
        r.char_code  = code;
        r.buffer_len = blen;
        return r;
    endfunction

    function automatic glyph_req_t load_req(input logic [7:0] idx, input logic [15:0] first,
                                            input logic [15:0] last);
        glyph_req_t r;
        r             = '0;
        r.req_type    = REQ_LOAD;
        r.block_index = idx;
        r.block_first = first;
        r.block_last  = last;
        return r;
    endfunction

    function automatic script_row_t row_item(input glyph_req_t r);
        script_row_t row;
        row     = '0;
        row.req = r;
        return row;
    endfunction

    function automatic script_row_t row_want(input glyph_req_t r, input logic [1:0] st,
                                             input logic [31:0] addr);
        script_row_t row;
        row             = '0;
        row.req         = r;
        row.typed       = 1'b1;
        row.want.status = st;
        row.want.addr   = addr;
        return row;
    endfunction

    function automatic script_row_t row_reg(input logic [1:0] idx, input logic [31:0] val);
        script_row_t row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at beat %0d: %s got 0x%0h, expected 0x%0h",
                     beats_checked, what, got, want);
    endtask

    // offers one beat, then records what it should produce once accepted
    task automatic send_glyph(input glyph_req_t r, input logic typed, input glyph_result_t want);
        glyph_result_t exp_r;
        logic          hs;
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.block_last, r.block_first, r.block_index, r.buffer_len, r.char_code};
        s_axis_tuser  <= r.req_type;
        do begin
            @(negedge aclk);
            hs = s_axis_tready;
            @(posedge aclk);
        end while (!hs);
        exp_r = predict_glyph(r);
        if (typed)
            exp_r = want;
        pending_glyphs.push_back(exp_r);
    endtask

    // registers change only with the block drained
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic hs;
        s_axis_tvalid <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
            hs = cfg_ready;
            @(posedge aclk);
        end while (!hs);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CODE_TYPE:    shadow_code_type = val[0];
            REG_PATTERN_BASE: shadow_base      = val;
            REG_PATTERN_SIZE: shadow_size      = val[7:0];
            REG_BLOCK_COUNT:  shadow_blocks    = val[8:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        glyph_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_glyphs.size() == 0) begin
                report_mismatch("beat with nothing pending, status", {30'd0, m_axis_tuser}, 32'd0);
            end else begin
                want = pending_glyphs.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", {30'd0, m_axis_tuser}, {30'd0, want.status});
                if (m_axis_tdata !== want.addr)
                    report_mismatch("glyph address", m_axis_tdata, want.addr);
                status_seen[want.status]++;
            end
            beats_checked++;
        end
    end

    // result side: random stalls, plus two long hold-offs so the input backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if ((beats_checked >= 300 && holds_done == 0)
                  || (beats_checked >= 1100 && holds_done == 1)) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_done    <= holds_done + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(negedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_glyphs.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        glyph_req_t    r;
        glyph_result_t no_want;
        script_row_t   row;
        logic [15:0]   cursor;
        int unsigned   span;
        int unsigned   pick;
        int unsigned   walk_n;
        int unsigned   seg_items;
        logic [8:0]    blocks;
        logic [7:0]    size;
        logic [31:0]   base;

        no_want       = '0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_CODE_TYPE;
        cfg_data      <= 32'd0;

        // register defaults after reset, single-byte extremes and refusals
        script.push_back(row_want(lookup_req(16'h0000, 16'd1), ST_FOUND, 32'd0));
        script.push_back(row_want(lookup_req(16'h00FF, 16'hFFFF), ST_FOUND, 32'd255));
        script.push_back(row_want(lookup_req(16'h0100, 16'd1), ST_ABSENT, 32'd0));
        script.push_back(row_want(lookup_req(16'hFFFF, 16'd5), ST_ABSENT, 32'd0));
        script.push_back(row_want(lookup_req(16'h0005, 16'd0), ST_SMALL, 32'd0));
        script.push_back(row_reg(REG_PATTERN_BASE, 32'hFFFF_FFF0));
        script.push_back(row_reg(REG_PATTERN_SIZE, 32'd255));
        // address wraps past 32 bits
        script.push_back(row_item(lookup_req(16'h00FF, 16'd255)));
        script.push_back(row_want(lookup_req(16'h0001, 16'd254), ST_SMALL, 32'd0));
        // zero pattern size: every buffer passes and the address is the base
        script.push_back(row_reg(REG_PATTERN_SIZE, 32'd0));
        script.push_back(row_want(lookup_req(16'h00C8, 16'd0), ST_FOUND, 32'hFFFF_FFF0));
        script.push_back(row_want(load_req(8'd0, 16'h0100, 16'h01FF), ST_LOADED, 32'd0));
        // inverted range that still advances the running index
        script.push_back(row_want(load_req(8'd1, 16'h8000, 16'h7FFF), ST_LOADED, 32'd0));
        script.push_back(row_want(load_req(8'd2, 16'hFF00, 16'hFFFF), ST_LOADED, 32'd0));
        script.push_back(row_want(load_req(8'd3, 16'h0050, 16'h0060), ST_LOADED, 32'd0));
        script.push_back(row_want(load_req(8'd255, 16'hFFFF, 16'h0000), ST_LOADED, 32'd0));
        script.push_back(row_reg(REG_CODE_TYPE, {31'd0, CODE_DOUBLE}));
        script.push_back(row_reg(REG_PATTERN_SIZE, 32'd16));
        script.push_back(row_reg(REG_PATTERN_BASE, 32'h1000_0000));
        script.push_back(row_reg(REG_BLOCK_COUNT, 32'd4));
        script.push_back(row_item(lookup_req(16'h0150, 16'd16)));
        script.push_back(row_item(lookup_req(16'hFFFF, 16'hFFFF)));
        script.push_back(row_item(lookup_req(16'h8000, 16'd16)));
        script.push_back(row_item(lookup_req(16'h0055, 16'd32)));
        script.push_back(row_want(lookup_req(16'h0005, 16'd15), ST_SMALL, 32'd0));
        script.push_back(row_item(lookup_req(16'h0040, 16'd16)));
        // no blocks in use: nothing can match
        script.push_back(row_reg(REG_BLOCK_COUNT, 32'd0));
        script.push_back(row_want(lookup_req(16'h0150, 16'd100), ST_ABSENT, 32'd0));
        script.push_back(row_reg(REG_BLOCK_COUNT, 32'd1));
        script.push_back(row_item(lookup_req(16'h01FF, 16'd16)));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            row = script[i];
            if (row.is_reg)
                write_reg(row.reg_idx, row.reg_val);
            else
                send_glyph(row.req, row.typed, row.want);
        end

        // fill the whole range table so any block count walks written entries only
        cursor = 16'($urandom_range(65535));
        for (int i = 0; i < MAX_RANGES; i++) begin
            span = ($urandom_range(9) == 0) ? $urandom_range(4000) : $urandom_range(48, 1);
            r             = '0;
            r.req_type    = REQ_LOAD;
            r.char_code   = 16'($urandom);
            r.buffer_len  = 16'($urandom);
            r.block_index = 8'(i);
            r.block_first = cursor;
            if ($urandom_range(19) == 0)
                r.block_last = 16'(cursor - 16'd1 - $urandom_range(100));
            else
                r.block_last = 16'(cursor + span - 1);
            cursor = 16'(cursor + span + $urandom_range(3));
            send_glyph(r, 1'b0, no_want);
        end

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin src_idle_pct = 10; dst_idle_pct = 85; end
                1: begin src_idle_pct = 85; dst_idle_pct = 10; end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            for (int seg = 0; seg < 5; seg++) begin
                case ($urandom_range(7))
                    0:       blocks = 9'd0;
                    1:       blocks = 9'd256;
                    2:       blocks = 9'($urandom_range(511, 257));
                    default: blocks = 9'($urandom_range(24, 1));
                endcase
                case ($urandom_range(5))
                    0:       size = 8'd0;
                    1:       size = 8'd1;
                    2:       size = 8'd255;
                    default: size = 8'($urandom_range(255, 1));
                endcase
                case ($urandom_range(3))
                    0:       base = 32'd0;
                    1:       base = 32'hFFFF_FFFF;
                    default: base = $urandom;
                endcase
                if (seg == 0)
                    blocks = (mode == 0) ? 9'd256 : 9'd511;
                if (seg == 1) begin
                    size = (mode == 1) ? 8'd0 : 8'd255;
                    base = 32'hFFFF_FFFF;
                end
                write_reg(REG_CODE_TYPE,
                          ($urandom_range(9) < 7) ? {31'd0, CODE_DOUBLE} : {31'd0, CODE_SINGLE});
                write_reg(REG_PATTERN_BASE, base);
                write_reg(REG_PATTERN_SIZE, {24'd0, size});
                write_reg(REG_BLOCK_COUNT, {23'd0, blocks});

                walk_n    = (shadow_blocks > MAX_RANGES) ? MAX_RANGES : shadow_blocks;
                seg_items = (walk_n > 64) ? 45 : 110;
                for (int k = 0; k < seg_items; k++) begin
                    r             = '0;
                    r.char_code   = 16'($urandom);
                    r.buffer_len  = 16'($urandom);
                    r.block_index = 8'($urandom);
                    r.block_first = 16'($urandom);
                    r.block_last  = 16'($urandom);
                    pick = $urandom_range(99);
                    if (pick < 8) begin
                        r.req_type = REQ_LOAD;
                        if ($urandom_range(1) == 1)
                            r.block_last = 16'(r.block_first + $urandom_range(64));
                    end else begin
                        r.req_type = REQ_LOOKUP;
                        if (pick < 18) begin
                            if (shadow_size != 0)
                                r.buffer_len = 16'($urandom_range(shadow_size - 1));
                        end else if (pick < 90) begin
                            r.buffer_len = 16'($urandom_range(65535, shadow_size));
                        end
                        if (shadow_code_type == CODE_SINGLE) begin
                            if ($urandom_range(9) < 7)
                                r.char_code = 16'($urandom_range(255));
                        end else if (walk_n != 0 && $urandom_range(3) != 0) begin
                            // aim inside a block in use
                            pick = $urandom_range(walk_n - 1);
                            if (ranges_first[pick] <= ranges_last[pick])
                                r.char_code = 16'($urandom_range(ranges_last[pick],
                                                                 ranges_first[pick]));
                        end
                    end
                    send_glyph(r, 1'b0, no_want);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_glyphs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d result beats: %0d found, %0d buffer too small, %0d absent, %0d loads",
                 beats_checked, status_seen[ST_FOUND], status_seen[ST_SMALL],
                 status_seen[ST_ABSENT], status_seen[ST_LOADED]);
        $display("%0d register writes across three stall mixes, %0d long result hold-offs",
                 reg_writes, holds_done);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
